// File: sv/ifdc_pkg.sv
// Shared types and constants for the DFT impedance calculator.
package ifdc_pkg;

    localparam int ABS_W   = 17;
    localparam int SUM_W   = 34;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 34;
    localparam int MAG_W   = 24;
    localparam int REF_W   = 20;
    localparam int PROD_W  = 44;
    localparam int IMP_W   = 32;
    localparam int CNT_W   = 6;
    localparam int SQRT_ITERS = RAD_W / 2;
    localparam int DIV_ITERS  = PROD_W;

    localparam logic [REF_W-1:0] REF_RESET = REF_W'(22000);

    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_MEASURE   = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SATURATED = 2'd1;
    localparam logic [1:0] ST_NO_CAL    = 2'd2;

    typedef struct packed {
        logic load;
        logic sq_re;
        logic sq_im;
        logic sqrt_step;
        logic mag_load;
        logic mul;
        logic div_step;
        logic out_load;
    } ifdc_cmd_t;

    typedef struct packed {
        logic op;
        logic cal_valid;
        logic mag_zero;
        logic out_busy;
    } ifdc_stat_t;

endpackage

// File: sv/ifdc_ctrl.sv
// Sequencer for the impedance calculator: steps the square root and divider.
module ifdc_ctrl import ifdc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ifdc_stat_t stat,
    output ifdc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE, SQ_RE, SQ_IM, SQRT, MAG, MUL, DIV, DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign s_tready = (state_reg == IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = SQ_RE;
                end
            end
            SQ_RE: begin
                cmd.sq_re  = 1'b1;
                state_next = SQ_IM;
            end
            SQ_IM: begin
                cmd.sq_im  = 1'b1;
                cnt_next   = CNT_W'(SQRT_ITERS - 1);
                state_next = SQRT;
            end
            SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = MAG;
                end
            end
            MAG: begin
                cmd.mag_load = 1'b1;
                state_next   = MUL;
            end
            MUL: begin
                cmd.mul  = 1'b1;
                cnt_next = CNT_W'(DIV_ITERS - 1);
                if (stat.op == OP_CALIBRATE || !stat.cal_valid || stat.mag_zero) begin
                    state_next = DONE;
                end else begin
                    state_next = DIV;
                end
            end
            DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = DONE;
                end
            end
            DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: sv/ifdc_dp.sv
// Datapath: squares, bitwise square root, gain multiply, restoring divider, output register.
module ifdc_dp import ifdc_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [REF_W-1:0]  cfg_wdata,
    input  logic [31:0]       s_tdata,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,
    output logic [1:0]        m_tuser,
    input  ifdc_cmd_t         cmd,
    output ifdc_stat_t        stat
);

    logic [REF_W-1:0]  ref_reg;
    logic              op_reg;
    logic [ABS_W-1:0]  re_reg, im_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  cal_mag_reg;
    logic              cal_valid_reg;
    logic [PROD_W-1:0] dvd_reg;
    logic [MAG_W-1:0]  drem_reg;
    logic              m_tvalid_reg;
    logic [IMP_W-1:0]  imp_out_reg;
    logic [MAG_W-1:0]  mag_out_reg;
    logic [1:0]        st_out_reg;

    logic [ABS_W-1:0]   re_abs, im_abs, sq_in;
    logic [SUM_W-1:0]   sq_prod, sum_full;
    logic [REM_W+1:0]   r_shift, r_trial;
    logic               r_ge;
    logic [MAG_W:0]     d_shift;
    logic               d_ge;
    logic [IMP_W-1:0]   imp_next;
    logic [1:0]         st_next;

    function automatic logic [ABS_W-1:0] abs16(input logic [15:0] v);
        logic [ABS_W-1:0] x;
        x = {1'b0, v};
        if (v[15]) begin
            x = ABS_W'(17'h10000) - x;
        end
        return x;
    endfunction

    assign re_abs   = abs16(s_tdata[15:0]);
    assign im_abs   = abs16(s_tdata[31:16]);
    assign sq_in    = cmd.sq_re ? re_reg : im_reg;
    assign sq_prod  = sq_in * sq_in;
    assign sum_full = sum_reg + sq_prod;

    assign r_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign r_trial = {root_reg, 2'b01};
    assign r_ge    = (r_shift >= r_trial);

    assign d_shift = {drem_reg, dvd_reg[PROD_W-1]};
    assign d_ge    = (d_shift >= {1'b0, mag_reg});

    always_comb begin
        imp_next = '0;
        st_next  = ST_OK;
        if (op_reg == OP_MEASURE) begin
            if (!cal_valid_reg) begin
                st_next = ST_NO_CAL;
            end else if (mag_reg == '0 || |dvd_reg[PROD_W-1:IMP_W]) begin
                imp_next = '1;
                st_next  = ST_SATURATED;
            end else begin
                imp_next = dvd_reg[IMP_W-1:0];
            end
        end
    end

    assign stat.op        = op_reg;
    assign stat.cal_valid = cal_valid_reg;
    assign stat.mag_zero  = (mag_reg == '0);
    assign stat.out_busy  = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {mag_out_reg, imp_out_reg};
    assign m_tuser  = st_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg       <= REF_RESET;
            cal_valid_reg <= 1'b0;
            cal_mag_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                ref_reg <= cfg_wdata;
            end
            if (cmd.mul && op_reg == OP_CALIBRATE) begin
                cal_mag_reg   <= mag_reg;
                cal_valid_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_tuser;
            re_reg <= re_abs;
            im_reg <= im_abs;
        end
        if (cmd.sq_re) begin
            sum_reg <= sq_prod;
        end
        if (cmd.sq_im) begin
            rad_reg  <= RAD_W'({{(RAD_W-SUM_W){1'b0}}, sum_full} << (2 * FRACTION_BITS));
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            rad_reg <= rad_reg << 2;
            if (r_ge) begin
                rem_reg  <= REM_W'(r_shift - r_trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= REM_W'(r_shift);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.mag_load) begin
            mag_reg <= (|root_reg[ROOT_W-1:MAG_W]) ? '1 : root_reg[MAG_W-1:0];
        end
        if (cmd.mul) begin
            dvd_reg  <= PROD_W'(ref_reg * cal_mag_reg);
            drem_reg <= '0;
        end
        if (cmd.div_step) begin
            if (d_ge) begin
                drem_reg <= MAG_W'(d_shift - {1'b0, mag_reg});
                dvd_reg  <= {dvd_reg[PROD_W-2:0], 1'b1};
            end else begin
                drem_reg <= d_shift[MAG_W-1:0];
                dvd_reg  <= {dvd_reg[PROD_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            imp_out_reg <= imp_next;
            mag_out_reg <= mag_reg;
            st_out_reg  <= st_next;
        end
    end

endmodule

// File: sv/impedance_from_dft_calibrated.sv
// Top level of the calibrated impedance calculator from DFT real/imaginary results.
//
// Input channel (s_): one transaction per DFT result; s_tuser is the op
// (0 calibrate against the reference load, 1 measure), s_tdata the real and
// imaginary parts. Output channel (m_): one transaction per input with the
// impedance, the magnitude (FRACTION_BITS fraction bits) and a status code.
// cfg_we/cfg_wdata write reference_ohms; write only while the block is idle.
// Calibrate items, measures before calibration and zero magnitudes skip the
// divider steps and go from the multiply straight to the output load.
// One item is in work at a time; s_tready is high only while idle, so a new
// item is accepted only after the last one has gone to the output register.
// The work is done by the 32-step square root (two radicand bits per cycle)
// and the 44-step restoring divider (one quotient bit per cycle).
// The result sits in an output register: the next item is accepted while it
// waits; if m_tready stays low, a finished item holds in the datapath until
// the register frees. Reset clears the calibration, sets reference_ohms to
// 22000 and drops m_tvalid.
module impedance_from_dft_calibrated import ifdc_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [REF_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [15:0] real_value, [31:16] imag_value
    input  logic              s_tuser,   // [0] op
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,   // [31:0] impedance_ohms, [55:32] magnitude_fixed
    output logic [1:0]        m_tuser    // [1:0] status
);

    ifdc_cmd_t  cmd;
    ifdc_stat_t stat;

    ifdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ifdc_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
